FILE: hdl/assert_macros.svh
// Shared assertion macros. Every macro samples on the rising clock edge and
// is switched off while the given reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/ic3_pkg.sv
`timescale 1ns / 1ps

package ic3_pkg;

   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 1023;

   localparam int PIX_W      = 8;
   localparam int DIM_W      = 10;
   localparam int COEF_W     = 16;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int TAP_SUM_W   = PIX_W + 2;
   localparam int PROD_W      = COEF_W + TAP_SUM_W;
   localparam int CPROD_W     = COEF_W + PIX_W;
   localparam int ACC_W       = PROD_W + 2;

   localparam logic [PIX_W-1:0] PIX_MAX = '1;

   localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = DIM_W'(500);
   localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = DIM_W'(500);
   localparam logic [COEF_W-1:0] RST_COEF         = COEF_W'(7281);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_COEF_CORNER  = 3'd2,
      REG_COEF_EDGE    = 3'd3,
      REG_COEF_CENTER  = 3'd4
   } csr_reg_type;

   // Border flags of the output position, whether the word yields a result, and last pixel.
   typedef struct packed {
      logic has_result;
      logic up;
      logic dn;
      logic lf;
      logic rt;
      logic last;
   } tap_ctl_type;

   typedef struct packed {
      logic [TAP_SUM_W-1:0] corner_sum;
      logic [TAP_SUM_W-1:0] edge_sum;
      logic [PIX_W-1:0]     center_pix;
      logic                 last;
   } tap_sum_type;

   typedef struct packed {
      logic [PROD_W-1:0]  corner_prod;
      logic [PROD_W-1:0]  edge_prod;
      logic [CPROD_W-1:0] center_prod;
      logic               last;
   } prod_type;

endpackage

FILE: hdl/ic3_position.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ic3_position import ic3_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [DIM_W-1:0]             image_width,
   input  logic [DIM_W-1:0]             image_height,
   output logic [$clog2(MAX_WIDTH)-1:0] col,
   output tap_ctl_type                  ctl
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int WCMP_W = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;
   localparam int HCMP_W = ((ROW_W > DIM_W) ? ROW_W : DIM_W) + 1;
   localparam logic [WCMP_W-1:0] MAX_W_C = WCMP_W'(MAX_WIDTH);
   localparam logic [HCMP_W-1:0] MAX_H_C = HCMP_W'(MAX_HEIGHT);

   // input row only tells the first row, the second row and later rows apart
   localparam logic [1:0] ROW_FIRST  = 2'd0;
   localparam logic [1:0] ROW_SECOND = 2'd1;
   localparam logic [1:0] ROW_LATER  = 2'd2;

   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [1:0]       in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;

   logic [WCMP_W-1:0] w_raw, w_eff, col_next, ocol_inc;
   logic [HCMP_W-1:0] h_raw, h_eff, orow_inc;
   logic              pre_wrap, post_wrap;
   logic [COL_W-1:0]  col_now;
   logic [1:0]        row_now;

   function automatic logic [1:0] row_step(input logic [1:0] r);
      return (r == ROW_LATER) ? ROW_LATER : r + 2'd1;
   endfunction

   assign w_raw = WCMP_W'(image_width);
   assign h_raw = HCMP_W'(image_height);

   always_comb begin
      if (image_width == '0) begin
         w_eff = WCMP_W'(1);
      end else if (w_raw > MAX_W_C) begin
         w_eff = MAX_W_C;
      end else begin
         w_eff = w_raw;
      end
      if (image_height == '0) begin
         h_eff = HCMP_W'(1);
      end else if (h_raw > MAX_H_C) begin
         h_eff = MAX_H_C;
      end else begin
         h_eff = h_raw;
      end
   end

   always_comb begin
      pre_wrap  = WCMP_W'(in_col_ff) >= w_eff;
      col_now   = pre_wrap ? '0 : in_col_ff;
      row_now   = pre_wrap ? row_step(in_row_ff) : in_row_ff;
      col_next  = WCMP_W'(col_now) + WCMP_W'(1);
      post_wrap = col_next >= w_eff;
      ocol_inc  = WCMP_W'(out_col_ff) + WCMP_W'(1);
      orow_inc  = HCMP_W'(out_row_ff) + HCMP_W'(1);

      ctl.has_result = (row_now == ROW_LATER) || ((row_now == ROW_SECOND) && (col_now != '0));
      ctl.up   = out_row_ff != '0;
      ctl.dn   = orow_inc < h_eff;
      ctl.lf   = out_col_ff != '0;
      ctl.rt   = ocol_inc < w_eff;
      ctl.last = !ctl.dn && !ctl.rt;

      in_col_in  = post_wrap ? '0 : col_next[COL_W-1:0];
      in_row_in  = post_wrap ? row_step(row_now) : row_now;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (ctl.has_result) begin
         if (ctl.last) begin
            in_col_in  = '0;
            in_row_in  = ROW_FIRST;
            out_col_in = '0;
            out_row_in = '0;
         end else if (!ctl.rt) begin
            out_col_in = '0;
            out_row_in = orow_inc[ROW_W-1:0];
         end else begin
            out_col_in = ocol_inc[COL_W-1:0];
         end
      end
   end

   assign col = col_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= ROW_FIRST;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (accept) begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   `ASSERT_SAME(a_first_row_silent, clock, reset, accept && (in_row_ff == ROW_FIRST), !ctl.has_result, "result from first input row")
   `ASSERT_NEXT(a_new_image_silent, clock, reset, accept && ctl.has_result && ctl.last, !ctl.has_result, "no restart after last pixel")

endmodule

FILE: hdl/ic3_line_buffer.sv
`timescale 1ns / 1ps

module ic3_line_buffer import ic3_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   input  logic                         wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  logic [PIX_W-1:0]             wr_upper,
   input  logic [PIX_W-1:0]             wr_lower,
   output logic [PIX_W-1:0]             rd_upper,
   output logic [PIX_W-1:0]             rd_lower
);

   logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
   logic [PIX_W-1:0] lower_mem [MAX_WIDTH];

   logic [PIX_W-1:0] rd_upper_ff, rd_lower_ff;
   logic [PIX_W-1:0] fwd_upper_ff, fwd_lower_ff;
   logic             fwd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr] <= wr_upper;
         lower_mem[wr_addr] <= wr_lower;
      end
      if (rd_en) begin
         rd_upper_ff  <= upper_mem[rd_addr];
         rd_lower_ff  <= lower_mem[rd_addr];
         fwd_upper_ff <= wr_upper;
         fwd_lower_ff <= wr_lower;
      end
   end

   // read and write of one column on the same edge: take the written word
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_hit_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_upper = fwd_hit_ff ? fwd_upper_ff : rd_upper_ff;
   assign rd_lower = fwd_hit_ff ? fwd_lower_ff : rd_lower_ff;

endmodule

FILE: hdl/ic3_window.sv
`timescale 1ns / 1ps

module ic3_window import ic3_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift,
   input  logic [PIX_W-1:0] new_upper,
   input  logic [PIX_W-1:0] new_lower,
   input  logic [PIX_W-1:0] new_pix,
   input  tap_ctl_type      ctl,
   output tap_sum_type      taps
);

   // row-major, column 2 newest
   logic [PIX_W-1:0] win_ff [9];
   logic [PIX_W-1:0] win_in [9];

   logic [PIX_W-1:0] tap_c, tap_t, tap_b, tap_l, tap_r;
   logic [PIX_W-1:0] tap_tl, tap_tr, tap_bl, tap_br;
   tap_sum_type      taps_ff, taps_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[3*k]   = win_ff[3*k+1];
         win_in[3*k+1] = win_ff[3*k+2];
      end
      win_in[2] = new_upper;
      win_in[5] = new_lower;
      win_in[8] = new_pix;

      tap_c  = win_in[4];
      tap_t  = ctl.up ? win_in[1] : tap_c;
      tap_b  = ctl.dn ? win_in[7] : tap_c;
      tap_l  = ctl.lf ? win_in[3] : tap_c;
      tap_r  = ctl.rt ? win_in[5] : tap_c;
      tap_tl = (ctl.up && ctl.lf) ? win_in[0] : tap_c;
      tap_tr = (ctl.up && ctl.rt) ? win_in[2] : tap_c;
      tap_bl = (ctl.dn && ctl.lf) ? win_in[6] : tap_c;
      tap_br = (ctl.dn && ctl.rt) ? win_in[8] : tap_c;

      taps_in.corner_sum = TAP_SUM_W'(tap_tl) + TAP_SUM_W'(tap_tr)
                         + TAP_SUM_W'(tap_bl) + TAP_SUM_W'(tap_br);
      taps_in.edge_sum   = TAP_SUM_W'(tap_t) + TAP_SUM_W'(tap_b)
                         + TAP_SUM_W'(tap_l) + TAP_SUM_W'(tap_r);
      taps_in.center_pix = tap_c;
      taps_in.last       = ctl.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
      end else if (shift) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= win_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         taps_ff <= taps_in;
      end
   end

   assign taps = taps_ff;

endmodule

FILE: hdl/ic3_mac.sv
`timescale 1ns / 1ps

module ic3_mac import ic3_pkg::*; (
   input  logic              clock,
   input  logic              prod_load,
   input  logic              out_load,
   input  tap_sum_type       taps,
   input  logic [COEF_W-1:0] coef_corner,
   input  logic [COEF_W-1:0] coef_edge,
   input  logic [COEF_W-1:0] coef_center,
   output logic [PIX_W-1:0]  pixel_out,
   output logic              last_pixel
);

   prod_type prod_ff, prod_in;

   logic [ACC_W-1:0]        acc_sum;
   logic [ACC_W-FRAC_W-1:0] acc_int;
   logic [PIX_W-1:0]        pixel_out_ff, pixel_out_in;
   logic                    last_pixel_ff;

   always_comb begin
      prod_in.corner_prod = PROD_W'(coef_corner) * PROD_W'(taps.corner_sum);
      prod_in.edge_prod   = PROD_W'(coef_edge) * PROD_W'(taps.edge_sum);
      prod_in.center_prod = CPROD_W'(coef_center) * CPROD_W'(taps.center_pix);
      prod_in.last        = taps.last;
   end

   always_comb begin
      acc_sum = ACC_W'(prod_ff.corner_prod) + ACC_W'(prod_ff.edge_prod)
              + ACC_W'(prod_ff.center_prod);
      acc_int = acc_sum[ACC_W-1:FRAC_W];
      if (acc_int > (ACC_W-FRAC_W)'(PIX_MAX)) begin
         pixel_out_in = PIX_MAX;
      end else begin
         pixel_out_in = acc_int[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (prod_load) begin
         prod_ff <= prod_in;
      end
      if (out_load) begin
         pixel_out_ff  <= pixel_out_in;
         last_pixel_ff <= prod_ff.last;
      end
   end

   assign pixel_out  = pixel_out_ff;
   assign last_pixel = last_pixel_ff;

endmodule

FILE: hdl/image_conv3x3_filter.sv
// Channel  Ports                                          Dir  Word
// req      req_valid req_stall req_pixel_in req_drain     in   pixel or flush tick
// rsp      rsp_valid rsp_stall rsp_pixel_out rsp_last_pixel out filtered pixel
// csr      csr_write csr_index csr_data                   in   register write
//
// One word per cycle sustained while rsp_stall is low; the line buffers take one read
// and one write a cycle. Once accepted, a word that yields a result passes stages B,
// C and D into the output register; results trail the input by image_width+1 words.
// Reset clears counters, window and pipeline valids; line buffers keep their content.
// rsp_stall backs up through the four stages; req_stall rises only once all are full.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module image_conv3x3_filter import ic3_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIX_W-1:0]      req_pixel_in,
   input  logic                  req_drain,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_pixel_out,
   output logic                  rsp_last_pixel,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic [DIM_W-1:0]  image_width_ff, image_height_ff;
   logic [COEF_W-1:0] coef_corner_ff, coef_edge_ff, coef_center_ff;

   logic b_valid_ff, b_valid_in;
   logic c_valid_ff, c_valid_in;
   logic d_valid_ff, d_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free, d_free, c_free, b_free;
   logic d_go, c_go, b_go, accept;

   logic [COL_W-1:0] pos_col, b_col_ff;
   tap_ctl_type      pos_ctl, b_ctl_ff;
   logic [PIX_W-1:0] b_pix_ff;
   logic [PIX_W-1:0] lb_upper, lb_lower;
   tap_sum_type      taps;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= RST_IMAGE_WIDTH;
         image_height_ff <= RST_IMAGE_HEIGHT;
         coef_corner_ff  <= RST_COEF;
         coef_edge_ff    <= RST_COEF;
         coef_center_ff  <= RST_COEF;
      end else if (csr_write) begin
         unique case (csr_reg_type'(csr_index))
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_data[DIM_W-1:0];
            REG_IMAGE_HEIGHT: image_height_ff <= csr_data[DIM_W-1:0];
            REG_COEF_CORNER:  coef_corner_ff  <= csr_data[COEF_W-1:0];
            REG_COEF_EDGE:    coef_edge_ff    <= csr_data[COEF_W-1:0];
            REG_COEF_CENTER:  coef_center_ff  <= csr_data[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   // stage B: line buffer read data, C: tap sums, D: products, then output
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      d_free    = !d_valid_ff || out_free;
      c_free    = !c_valid_ff || d_free;
      b_free    = !b_valid_ff || c_free;
      d_go      = d_valid_ff && out_free;
      c_go      = c_valid_ff && d_free;
      b_go      = b_valid_ff && c_free;
      req_stall = !b_free;
      accept    = req_valid && b_free;

      b_valid_in   = accept ? 1'b1 : (b_go ? 1'b0 : b_valid_ff);
      c_valid_in   = b_go ? b_ctl_ff.has_result : (c_go ? 1'b0 : c_valid_ff);
      d_valid_in   = c_go ? 1'b1 : (d_go ? 1'b0 : d_valid_ff);
      rsp_valid_in = d_go ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= c_valid_in;
         d_valid_ff   <= d_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_pix_ff <= req_drain ? '0 : req_pixel_in;
         b_col_ff <= pos_col;
         b_ctl_ff <= pos_ctl;
      end
   end

   ic3_position #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_position (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .col          (pos_col),
      .ctl          (pos_ctl)
   );

   ic3_line_buffer #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buffer (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (pos_col),
      .wr_en    (b_go),
      .wr_addr  (b_col_ff),
      .wr_upper (lb_lower),
      .wr_lower (b_pix_ff),
      .rd_upper (lb_upper),
      .rd_lower (lb_lower)
   );

   ic3_window u_window (
      .clock     (clock),
      .reset     (reset),
      .shift     (b_go),
      .new_upper (lb_upper),
      .new_lower (lb_lower),
      .new_pix   (b_pix_ff),
      .ctl       (b_ctl_ff),
      .taps      (taps)
   );

   ic3_mac u_mac (
      .clock       (clock),
      .prod_load   (c_go),
      .out_load    (d_go),
      .taps        (taps),
      .coef_corner (coef_corner_ff),
      .coef_edge   (coef_edge_ff),
      .coef_center (coef_center_ff),
      .pixel_out   (rsp_pixel_out),
      .last_pixel  (rsp_last_pixel)
   );

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_SAME(a_skid_accepts, clock, reset, rsp_valid && rsp_stall && !b_valid_ff, !req_stall, "input held with stage B empty")
   `ASSERT_NEXT(a_result_enters_c, clock, reset, b_go && b_ctl_ff.has_result, c_valid_ff, "result word lost after stage B")

endmodule
